>>> hw/rtl/spfm_pkg.sv
// Package for the sensor poll and fault monitor: register indexes, reset
// values of the configuration registers and packed request/result types.
// No dependencies.
`timescale 1ns / 1ps

package spfm_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_PROBE_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HUMID_ENABLE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PROBE_PERIOD_MS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CONVERT_WAIT_MS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUMID_PERIOD_MS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FAIL_LIMIT      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_COLD_LIMIT      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HOT_LIMIT       = 3'd7;

  // Register reset values (limits are 35.0 C and 40.0 C in 1/16 C)
  localparam logic               RST_PROBE_ENABLE    = 1'b1;
  localparam logic               RST_HUMID_ENABLE    = 1'b1;
  localparam logic [15:0]        RST_PROBE_PERIOD_MS = 16'd3000;
  localparam logic [15:0]        RST_CONVERT_WAIT_MS = 16'd750;
  localparam logic [15:0]        RST_HUMID_PERIOD_MS = 16'd2500;
  localparam logic [7:0]         RST_FAIL_LIMIT      = 8'd5;
  localparam logic signed [15:0] RST_COLD_LIMIT      = 16'sd560;
  localparam logic signed [15:0] RST_HOT_LIMIT       = 16'sd640;

  // Saturation values of the counters
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [7:0]  FAIL_MAX    = 8'hFF;

  // Stream widths
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;

  // One tick request; last member sits in the lowest bits
  typedef struct packed {
    logic               humid_ok;
    logic signed [10:0] air_reading;
    logic        [9:0]  humid_reading;
    logic               cold_present;
    logic signed [15:0] cold_reading;
    logic               hot_present;
    logic signed [15:0] hot_reading;
  } tick_req_t;

  // One result; last member sits in the lowest bits
  typedef struct packed {
    logic               overheat;
    logic               humid_fault;
    logic               cold_fault;
    logic               hot_fault;
    logic               temps_valid;
    logic        [9:0]  humidity;
    logic signed [10:0] air_temp;
    logic signed [15:0] cold_temp;
    logic signed [15:0] hot_temp;
    logic               humid_sample;
    logic               convert_start;
  } tick_res_t;

  localparam int unsigned ResW = $bits(tick_res_t);

endpackage

>>> hw/rtl/sensor_poll_fault_monitor_unit.sv
// Sensor poll and fault monitor: millisecond tick stream in, one status
// result per tick out. Uses spfm_pkg for types and register constants.
// A request passes the input register, then the update stage into the
// result register. Throughput: one request per cycle unless out_tready
// holds the result register; the state update is a single pass.
// Reset (rst_n low, synchronous): registers return to their defaults,
// counters, latched values and flags clear, both stages empty.
`timescale 1ns / 1ps

module sensor_poll_fault_monitor_unit
  import spfm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Request stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // fields from bit 0: hot_reading[15:0], hot_present, cold_reading[15:0],
  // cold_present, humid_reading[9:0], air_reading[10:0], humid_ok
  input  logic [InDataW-1:0]  in_tdata,
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // fields from bit 0: convert_start, humid_sample, hot_temp[15:0],
  // cold_temp[15:0], air_temp[10:0], humidity[9:0], temps_valid, hot_fault,
  // cold_fault, humid_fault, overheat, then zero padding
  output logic [OutDataW-1:0] out_tdata,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  logic               probe_enable_r;
  logic               humid_enable_r;
  logic [15:0]        probe_period_r;
  logic [15:0]        convert_wait_r;
  logic [15:0]        humid_period_r;
  logic [7:0]         fail_limit_r;
  logic signed [15:0] cold_limit_r;
  logic signed [15:0] hot_limit_r;

  // Monitor state
  logic [15:0]        since_probe_r, since_probe_nxt;
  logic [15:0]        since_req_r, since_req_nxt;
  logic               converting_r, converting_nxt;
  logic [15:0]        since_humid_r, since_humid_nxt;
  logic [7:0]         hot_fail_r, hot_fail_nxt;
  logic [7:0]         cold_fail_r, cold_fail_nxt;
  logic [7:0]         humid_fail_r, humid_fail_nxt;
  logic signed [15:0] hot_value_r, hot_value_nxt;
  logic signed [15:0] cold_value_r, cold_value_nxt;
  logic signed [10:0] air_value_r, air_value_nxt;
  logic [9:0]         humid_value_r, humid_value_nxt;
  logic               seen_good_r, seen_good_nxt;

  // Pipeline registers
  logic      s1_valid_r;
  tick_req_t s1_req_r;
  logic      out_valid_r;
  tick_res_t out_res_r;
  tick_res_t res_nxt;

  logic        advance;
  logic [15:0] since_probe_inc, since_req_inc, since_humid_inc;
  logic        start_c, conv_mid, take_c, sample_c;

  // Handshake: stage 1 moves on when the result register is free or drained
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - ResW){1'b0}}, out_res_r};

  // Tick update: saturating elapsed counters, probe and humidity scheduling
  always_comb begin
    since_probe_inc = (since_probe_r == ELAPSED_MAX) ? since_probe_r : since_probe_r + 16'd1;
    since_req_inc   = (since_req_r == ELAPSED_MAX) ? since_req_r : since_req_r + 16'd1;
    since_humid_inc = (since_humid_r == ELAPSED_MAX) ? since_humid_r : since_humid_r + 16'd1;

    start_c  = probe_enable_r && !converting_r && (since_probe_inc >= probe_period_r);
    since_probe_nxt = start_c ? 16'd0 : since_probe_inc;
    since_req_nxt   = start_c ? 16'd0 : since_req_inc;
    conv_mid = converting_r || start_c;
    take_c   = probe_enable_r && conv_mid && (since_req_nxt >= convert_wait_r);
    converting_nxt = take_c ? 1'b0 : conv_mid;

    hot_value_nxt  = hot_value_r;
    cold_value_nxt = cold_value_r;
    hot_fail_nxt   = hot_fail_r;
    cold_fail_nxt  = cold_fail_r;
    seen_good_nxt  = seen_good_r;
    if (take_c) begin
      if (s1_req_r.hot_present) begin
        hot_value_nxt = s1_req_r.hot_reading;
        hot_fail_nxt  = 8'd0;
        seen_good_nxt = 1'b1;
      end else begin
        hot_fail_nxt = (hot_fail_r == FAIL_MAX) ? hot_fail_r : hot_fail_r + 8'd1;
      end
      if (s1_req_r.cold_present) begin
        cold_value_nxt = s1_req_r.cold_reading;
        cold_fail_nxt  = 8'd0;
      end else begin
        cold_fail_nxt = (cold_fail_r == FAIL_MAX) ? cold_fail_r : cold_fail_r + 8'd1;
      end
    end

    sample_c = humid_enable_r && (since_humid_inc >= humid_period_r);
    since_humid_nxt = sample_c ? 16'd0 : since_humid_inc;
    humid_value_nxt = humid_value_r;
    air_value_nxt   = air_value_r;
    humid_fail_nxt  = humid_fail_r;
    if (sample_c) begin
      if (s1_req_r.humid_ok) begin
        humid_value_nxt = s1_req_r.humid_reading;
        air_value_nxt   = s1_req_r.air_reading;
        humid_fail_nxt  = 8'd0;
      end else begin
        humid_fail_nxt = (humid_fail_r == FAIL_MAX) ? humid_fail_r : humid_fail_r + 8'd1;
      end
    end

    // Flags from the updated state
    res_nxt.convert_start = start_c;
    res_nxt.humid_sample  = sample_c;
    res_nxt.hot_temp      = hot_value_nxt;
    res_nxt.cold_temp     = cold_value_nxt;
    res_nxt.air_temp      = air_value_nxt;
    res_nxt.humidity      = humid_value_nxt;
    res_nxt.temps_valid   = seen_good_nxt;
    res_nxt.hot_fault     = probe_enable_r && (hot_fail_nxt > fail_limit_r);
    res_nxt.cold_fault    = probe_enable_r && (cold_fail_nxt > fail_limit_r);
    res_nxt.humid_fault   = humid_enable_r && (humid_fail_nxt > fail_limit_r);
    res_nxt.overheat      = probe_enable_r &&
                            ((cold_value_nxt > cold_limit_r) || (hot_value_nxt > hot_limit_r));
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      probe_enable_r <= RST_PROBE_ENABLE;
      humid_enable_r <= RST_HUMID_ENABLE;
      probe_period_r <= RST_PROBE_PERIOD_MS;
      convert_wait_r <= RST_CONVERT_WAIT_MS;
      humid_period_r <= RST_HUMID_PERIOD_MS;
      fail_limit_r   <= RST_FAIL_LIMIT;
      cold_limit_r   <= RST_COLD_LIMIT;
      hot_limit_r    <= RST_HOT_LIMIT;
      since_probe_r  <= '0;
      since_req_r    <= '0;
      converting_r   <= 1'b0;
      since_humid_r  <= '0;
      hot_fail_r     <= '0;
      cold_fail_r    <= '0;
      humid_fail_r   <= '0;
      hot_value_r    <= '0;
      cold_value_r   <= '0;
      air_value_r    <= '0;
      humid_value_r  <= '0;
      seen_good_r    <= 1'b0;
    end else begin
      // Input stage occupancy
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      // Result stage occupancy
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Commit the tick update
      if (advance) begin
        since_probe_r <= since_probe_nxt;
        since_req_r   <= since_req_nxt;
        converting_r  <= converting_nxt;
        since_humid_r <= since_humid_nxt;
        hot_fail_r    <= hot_fail_nxt;
        cold_fail_r   <= cold_fail_nxt;
        humid_fail_r  <= humid_fail_nxt;
        hot_value_r   <= hot_value_nxt;
        cold_value_r  <= cold_value_nxt;
        air_value_r   <= air_value_nxt;
        humid_value_r <= humid_value_nxt;
        seen_good_r   <= seen_good_nxt;
      end
      // Register writes; disabling a path clears its failure counters
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROBE_ENABLE: begin
            probe_enable_r <= cfg_wdata[0];
            if (!cfg_wdata[0]) begin
              hot_fail_r  <= '0;
              cold_fail_r <= '0;
            end
          end
          REG_HUMID_ENABLE: begin
            humid_enable_r <= cfg_wdata[0];
            if (!cfg_wdata[0]) begin
              humid_fail_r <= '0;
            end
          end
          REG_PROBE_PERIOD_MS: probe_period_r <= cfg_wdata;
          REG_CONVERT_WAIT_MS: convert_wait_r <= cfg_wdata;
          REG_HUMID_PERIOD_MS: humid_period_r <= cfg_wdata;
          REG_FAIL_LIMIT:      fail_limit_r   <= cfg_wdata[7:0];
          REG_COLD_LIMIT:      cold_limit_r   <= cfg_wdata;
          REG_HOT_LIMIT:       hot_limit_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= tick_req_t'(in_tdata);
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  // Empty result register always frees the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // Full pipeline under backpressure takes no new request
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("request accepted into a blocked pipeline");

  // Every committed tick shows up as a result
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("committed tick produced no result");

  // A conversion only begins with a conversion request
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(converting_r) |-> $past(advance && start_c))
    else $error("conversion started without a request");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for sensor_poll_fault_monitor_unit: streams millisecond
// ticks under several register settings and checks every status result
// against an in-bench copy of the poll/fault logic. Depends on spfm_pkg.
`timescale 1ns / 1ps

module tb_top;
  import spfm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_CAP  = 200;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  sensor_poll_fault_monitor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register shadow
  bit                 probes_on    = RST_PROBE_ENABLE;
  bit                 humid_on     = RST_HUMID_ENABLE;
  logic        [15:0] probe_period = RST_PROBE_PERIOD_MS;
  logic        [15:0] conv_wait    = RST_CONVERT_WAIT_MS;
  logic        [15:0] humid_period = RST_HUMID_PERIOD_MS;
  logic        [7:0]  fail_lim     = RST_FAIL_LIMIT;
  logic signed [15:0] cold_lim     = RST_COLD_LIMIT;
  logic signed [15:0] hot_lim      = RST_HOT_LIMIT;

  // Monitor state shadow
  logic        [15:0] since_probe = '0;
  logic        [15:0] since_req   = '0;
  logic        [15:0] since_humid = '0;
  bit                 conv_busy   = 1'b0;
  logic        [7:0]  hot_fails   = '0;
  logic        [7:0]  cold_fails  = '0;
  logic        [7:0]  humid_fails = '0;
  logic signed [15:0] hot_lat     = '0;
  logic signed [15:0] cold_lat    = '0;
  logic signed [10:0] air_lat     = '0;
  logic        [9:0]  humid_lat   = '0;
  bit                 hot_seen    = 1'b0;

  tick_req_t   tick_backlog[$];
  tick_res_t   status_due[$];
  int unsigned err_count  = 0;
  int unsigned send_idle  = 0;
  int unsigned recv_idle  = 0;
  logic        stall_go   = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt  = 0;

  // Advance the shadow by one tick and return the status it should report
  function automatic tick_res_t poll_tick(tick_req_t t);
    tick_res_t s;
    s = '0;
    if (since_probe != ELAPSED_MAX) since_probe++;
    if (since_req != ELAPSED_MAX) since_req++;
    if (since_humid != ELAPSED_MAX) since_humid++;

    if (probes_on) begin
      if (!conv_busy && since_probe >= probe_period) begin
        s.convert_start = 1'b1;
        since_probe = '0;
        since_req   = '0;
        conv_busy   = 1'b1;
      end
      // Conversion done: latch present probes, count missing ones
      if (conv_busy && since_req >= conv_wait) begin
        if (t.hot_present) begin
          hot_lat   = t.hot_reading;
          hot_fails = '0;
          hot_seen  = 1'b1;
        end else if (hot_fails != FAIL_MAX) begin
          hot_fails++;
        end
        if (t.cold_present) begin
          cold_lat   = t.cold_reading;
          cold_fails = '0;
        end else if (cold_fails != FAIL_MAX) begin
          cold_fails++;
        end
        conv_busy = 1'b0;
      end
    end

    if (humid_on && since_humid >= humid_period) begin
      s.humid_sample = 1'b1;
      since_humid = '0;
      if (t.humid_ok) begin
        humid_lat   = t.humid_reading;
        air_lat     = t.air_reading;
        humid_fails = '0;
      end else if (humid_fails != FAIL_MAX) begin
        humid_fails++;
      end
    end

    s.hot_temp    = hot_lat;
    s.cold_temp   = cold_lat;
    s.air_temp    = air_lat;
    s.humidity    = humid_lat;
    s.temps_valid = hot_seen;
    if (probes_on) begin
      s.hot_fault  = hot_fails > fail_lim;
      s.cold_fault = cold_fails > fail_lim;
      s.overheat   = (cold_lat > cold_lim) || (hot_lat > hot_lim);
    end
    if (humid_on) s.humid_fault = humid_fails > fail_lim;
    return s;
  endfunction

  function automatic tick_req_t make_tick(logic [15:0] hot, bit hp, logic [15:0] cold,
                                          bit cp, logic [9:0] hum, logic [10:0] air, bit ok);
    tick_req_t t;
    t.hot_reading   = hot;
    t.hot_present   = hp;
    t.cold_reading  = cold;
    t.cold_present  = cp;
    t.humid_reading = hum;
    t.air_reading   = air;
    t.humid_ok      = ok;
    return t;
  endfunction

  // Random tick; half the probe readings sit right around the current limits
  function automatic tick_req_t rand_tick(int unsigned absent_pct);
    tick_req_t t;
    t.hot_present  = $urandom_range(0, 99) >= absent_pct;
    t.cold_present = $urandom_range(0, 99) >= absent_pct;
    t.humid_ok     = $urandom_range(0, 99) >= absent_pct;
    t.hot_reading  = $urandom_range(0, 1) ? 16'(hot_lim + $urandom_range(0, 16) - 8)
                                          : 16'($urandom);
    t.cold_reading = $urandom_range(0, 1) ? 16'(cold_lim + $urandom_range(0, 16) - 8)
                                          : 16'($urandom);
    t.humid_reading = 10'($urandom);
    t.air_reading   = 11'($urandom);
    return t;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_count++;
      // Keep the log bounded when the block is badly off
      if (err_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // One register write; the shadow follows at the same edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PROBE_ENABLE: begin
        probes_on = val[0];
        if (!val[0]) begin
          hot_fails  = '0;
          cold_fails = '0;
        end
      end
      REG_HUMID_ENABLE: begin
        humid_on = val[0];
        if (!val[0]) humid_fails = '0;
      end
      REG_PROBE_PERIOD_MS: probe_period = val;
      REG_CONVERT_WAIT_MS: conv_wait    = val;
      REG_HUMID_PERIOD_MS: humid_period = val;
      REG_FAIL_LIMIT:      fail_lim     = val[7:0];
      REG_COLD_LIMIT:      cold_lim     = val;
      REG_HOT_LIMIT:       hot_lim      = val;
      default: ;
    endcase
  endtask

  // Write every register; unused upper data bits carry noise
  task automatic setup(bit pe, bit he, logic [15:0] pp, logic [15:0] cw, logic [15:0] hp,
                       logic [7:0] fl, logic [15:0] cl, logic [15:0] hl);
    write_reg(REG_PROBE_ENABLE, {15'($urandom), pe});
    write_reg(REG_HUMID_ENABLE, {15'($urandom), he});
    write_reg(REG_PROBE_PERIOD_MS, pp);
    write_reg(REG_CONVERT_WAIT_MS, cw);
    write_reg(REG_HUMID_PERIOD_MS, hp);
    write_reg(REG_FAIL_LIMIT, {8'($urandom), fl});
    write_reg(REG_COLD_LIMIT, cl);
    write_reg(REG_HOT_LIMIT, hl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued request is accepted and every status is back;
  // look between edges so the handshake updates of the last edge have landed
  task automatic settle();
    @(negedge clk);
    while (tick_backlog.size() != 0 || in_tvalid || status_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver: predict on accept, then offer the next tick or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) status_due.push_back(poll_tick(tick_req_t'(in_tdata)));
      if (!in_tvalid || in_tready) begin
        if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_tdata  <= tick_backlog.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (stall_go) stall_left <= 400;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Status monitor
  always @(posedge clk) begin : result_monitor
    tick_res_t got;
    tick_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = tick_res_t'(out_tdata[ResW-1:0]);
        if (status_due.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_CAP)
            $display("%0t: unexpected status, expected none actual %0h", $time, out_tdata);
        end else begin
          want = status_due.pop_front();
          check_field("convert_start", want.convert_start, got.convert_start);
          check_field("humid_sample", want.humid_sample, got.humid_sample);
          check_field("hot_temp", want.hot_temp, got.hot_temp);
          check_field("cold_temp", want.cold_temp, got.cold_temp);
          check_field("air_temp", want.air_temp, got.air_temp);
          check_field("humidity", want.humidity, got.humidity);
          check_field("temps_valid", want.temps_valid, got.temps_valid);
          check_field("hot_fault", want.hot_fault, got.hot_fault);
          check_field("cold_fault", want.cold_fault, got.cold_fault);
          check_field("humid_fault", want.humid_fault, got.humid_fault);
          check_field("overheat", want.overheat, got.overheat);
          check_field("padding", 16'd0, 16'(out_tdata[OutDataW-1:ResW]));
        end
      end
      out_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned n_items;
    int unsigned absent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every tick converts and samples, field extremes, quick faults
    setup(1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 8'd1, 16'd0, 16'd0);
    tick_backlog.push_back(make_tick(16'h7FFF, 1, 16'h8000, 1, 10'd1023, 11'h3FF, 1));
    tick_backlog.push_back(make_tick(16'h8000, 1, 16'h7FFF, 1, 10'd0, 11'h400, 1));
    tick_backlog.push_back(make_tick(16'h0000, 0, 16'h0000, 0, 10'd0, 11'h000, 0));
    tick_backlog.push_back(make_tick(16'hFFFF, 0, 16'hFFFF, 0, 10'h3FF, 11'h7FF, 0));
    tick_backlog.push_back(make_tick(16'h1234, 0, 16'h4321, 0, 10'd500, 11'd300, 0));
    tick_backlog.push_back(make_tick(16'hFFFF, 1, 16'hFFFF, 1, 10'h3FF, 11'h7FF, 1));
    tick_backlog.push_back(make_tick(16'h0001, 1, 16'h0000, 0, 10'd1000, 11'h670, 1));
    settle();

    // Directed: request, then drop the probe path while converting
    setup(1'b1, 1'b1, 16'd0, 16'd5, 16'd2, 8'd0, 16'h8000, 16'h7FFF);
    repeat (2) tick_backlog.push_back(rand_tick(0));
    settle();
    setup(1'b0, 1'b0, 16'd0, 16'd5, 16'd2, 8'd0, 16'h8000, 16'h7FFF);
    repeat (3) tick_backlog.push_back(rand_tick(50));
    settle();
    // Re-enable: the pending readings land once the wait has run out
    setup(1'b1, 1'b1, 16'd0, 16'd5, 16'd2, 8'd0, 16'h8000, 16'h7FFF);
    repeat (6) tick_backlog.push_back(rand_tick(30));
    settle();

    // Random phases, each under its own register setting
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle = 35;
        recv_idle = 72;
      end else if (p < 8) begin
        send_idle = 72;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      n_items = $urandom_range(55, 75);
      absent  = $urandom_range(0, 50);
      case (p)
        0: setup(1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 8'd0, 16'h8000, 16'h8000);
        1: begin
          setup(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd254, 16'h7FFF, 16'h7FFF);
          n_items = 40;
        end
        2: begin
          // Long failure run: counters reach saturation above the top limit
          setup(1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 8'd254, 16'd0, 16'd0);
          n_items = 280;
        end
        3: begin
          // Limit at the counter ceiling: no fault can ever show
          setup(1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 8'd255, 16'd560, 16'd640);
          n_items = 40;
          absent  = 100;
        end
        default: begin
          setup($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
                16'($urandom_range(0, 10)),
                $urandom_range(0, 7) == 0 ? 8'($urandom_range(250, 255))
                                          : 8'($urandom_range(0, 6)),
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(400, 700)),
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(400, 700)));
        end
      endcase
      for (int i = 0; i < n_items; i++)
        tick_backlog.push_back(rand_tick((p == 2 && i < 270) ? 100 : absent));
      if (p == 9) begin
        // Receiver holds off while the sender keeps offering
        @(posedge clk);
        stall_go <= 1'b1;
        @(posedge clk);
        stall_go <= 1'b0;
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/spfm_pkg.sv
hw/rtl/sensor_poll_fault_monitor_unit.sv
tb/sv/tb_top.sv
